[hdl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants for the five-point derivative
// Holds the weight table, fixed field widths and the divider response type.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int STEP_W = 32;
    localparam int DER_W  = 40;
    localparam int DIV_W  = 36;   // 12 * step fits in 36 bits
    localparam int N_TAPS = 5;

    localparam logic [STEP_W-1:0] MIN_STEP_RST = 32'd6554;
    localparam logic [2:0]        ROW_LAST     = 3'd4;

    typedef logic signed [7:0] t_weight;

    // one-sided, off-centre, centred, off-centre and one-sided five-point rows
    localparam t_weight WEIGHTS [5][5] = '{
        '{-8'sd25,  8'sd48, -8'sd36,  8'sd16, -8'sd3 },
        '{-8'sd3,  -8'sd10,  8'sd18, -8'sd6,   8'sd1 },
        '{ 8'sd1,  -8'sd8,   8'sd0,   8'sd8,  -8'sd1 },
        '{-8'sd1,   8'sd6,  -8'sd18,  8'sd10,  8'sd3 },
        '{ 8'sd3,  -8'sd16,  8'sd36, -8'sd48,  8'sd25}
    };

    typedef struct packed {
        logic             done;
        logic [DER_W-1:0] derivative;
    } t_div_rsp;

    function automatic t_weight weight(input logic [2:0] row, input logic [2:0] col);
        t_weight w;
        w = 8'sd0;
        if (row < 3'd5 && col < 3'd5) begin
            w = WEIGHTS[row][col];
        end
        return w;
    endfunction

endpackage

[hdl/fpd_if.sv]
// ----------------------------------------------------------------------------
// fpd_if: valid/ready channels of the five-point derivative
// Input samples, output derivatives and the minimum-step write channel.
// ----------------------------------------------------------------------------
interface fpd_in_if #(parameter int SAMPLE_BITS = 32);
    import fpd_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [STEP_W-1:0]             step;
    logic                          last;
    modport source (output valid, sample, step, last, input ready);
    modport sink   (input valid, sample, step, last, output ready);
endinterface

interface fpd_out_if;
    import fpd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [DER_W-1:0] derivative;
    logic                    final_res;
    logic                    too_short;
    modport source (output valid, derivative, final_res, too_short, input ready);
    modport sink   (input valid, derivative, final_res, too_short, output ready);
endinterface

interface fpd_cfg_if;
    import fpd_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/fpd_mac.sv]
// ----------------------------------------------------------------------------
// fpd_mac: serial weighted sum over the sample window
// Accumulates one weight times one sample per cycle, over the five taps of a sum.
// ----------------------------------------------------------------------------
module fpd_mac #(
    parameter int SAMPLE_BITS = 32,
    parameter int ACC_W       = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [2:0]                    i_row,
    input  logic signed [SAMPLE_BITS-1:0] i_win [fpd_pkg::N_TAPS],
    output logic                          o_done,
    output logic signed [ACC_W-1:0]       o_acc
);
    import fpd_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [2:0]              r_idx;
    logic [2:0]              r_row;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] sx;
    logic signed [ACC_W-1:0] prod;
    t_weight                 w;

    // one tap product
    always_comb begin
        w    = weight(r_row, r_idx);
        sx   = ACC_W'(i_win[r_idx]);
        prod = ACC_W'(sx * w);
    end

    // step through the five taps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
                r_row  <= i_row;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + prod;
                if (r_idx == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[hdl/fpd_div.sv]
// ----------------------------------------------------------------------------
// fpd_div: bit-serial restoring divider with Q24.16 saturation
// Divides magnitude * 2^16 by 12 * step, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpd_div #(
    parameter int MAG_W = 39
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_neg,
    input  logic [MAG_W-1:0]               i_mag,
    input  logic [fpd_pkg::DIV_W-1:0]      i_dvsr,
    output fpd_pkg::t_div_rsp              o_rsp
);
    import fpd_pkg::*;

    localparam int DVD_W = MAG_W + 16;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [DER_W-1:0] DER_MAX = {1'b0, {(DER_W-1){1'b1}}};
    localparam logic [DER_W-1:0] DER_MIN = {1'b1, {(DER_W-1){1'b0}}};

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_dvsr;
    logic [DER_W:0]    r_q;
    logic              r_ovf;
    logic              r_neg;
    logic [DER_W-1:0]  r_res;
    logic [DIV_W:0]    rem_sh;
    logic              ge;
    logic              big;
    logic [DER_W-1:0]  sat;

    // trial subtract
    always_comb begin
        rem_sh = {r_rem[DIV_W-1:0], r_dvd[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_dvsr};
    end

    // saturate the finished quotient
    always_comb begin
        big = r_ovf | r_q[DER_W];
        if (r_neg) begin
            if (big || (r_q[DER_W-1] && |r_q[DER_W-2:0])) begin
                sat = DER_MIN;
            end else begin
                sat = DER_W'(0) - r_q[DER_W-1:0];
            end
        end else begin
            if (big || r_q[DER_W-1]) begin
                sat = DER_MAX;
            end else begin
                sat = r_q[DER_W-1:0];
            end
        end
    end

    // advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_dvd  <= {i_mag, 16'd0};
                r_rem  <= '0;
                r_dvsr <= i_dvsr;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_neg  <= i_neg;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - {1'b0, r_dvsr} : rem_sh;
                r_q   <= {r_q[DER_W-1:0], ge};
                r_ovf <= r_ovf | r_q[DER_W];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_res  <= sat;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done       = r_done;
    assign o_rsp.derivative = r_res;

endmodule

[hdl/five_point_derivative_top.sv]
// ----------------------------------------------------------------------------
// five_point_derivative_top: streaming five-point derivative, Q24.16 out
// Keeps a five-sample window and emits saturated derivatives in sequence.
// ----------------------------------------------------------------------------
// One sample is taken at a time; the block is ready again once all results
// caused by it have been placed in the output register. Each result takes a
// serial weighted sum, a bit-serial division and a handover to the output
// register, so a sample holds the block for each result it causes, up to
// three on a last sample (five on a last sample that is exactly the fifth).
// A too-short sequence gives one zero result marked final and too short.
// ----------------------------------------------------------------------------
module five_point_derivative_top #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpd_cfg_if.sink    i_cfg,
    fpd_in_if.sink     i_in,
    fpd_out_if.source  o_out
);
    import fpd_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + 8;
    localparam int MAG_W = SAMPLE_BITS + 7;

    typedef enum logic [1:0] {S_IDLE, S_MAC, S_DIV, S_OUT} t_state;

    t_state                        r_state;
    logic [STEP_W-1:0]             r_min_step;
    logic signed [SAMPLE_BITS-1:0] r_smp [N_TAPS];
    logic [STEP_W-1:0]             r_stp [N_TAPS];
    logic [2:0]                    r_seen;
    logic [4:0]                    r_jobs;
    logic [2:0]                    r_row;
    logic                          r_mac_go;
    logic                          r_short;
    logic                          r_clear;
    logic                          r_out_valid;
    logic [DER_W-1:0]              r_out_der;
    logic                          r_out_fin;
    logic                          r_out_short;

    logic                          accept;
    logic                          slot_free;
    logic                          out_load;
    logic [2:0]                    n_seen;
    logic [4:0]                    n_jobs;
    logic                          short_seq;
    logic                          mac_done;
    logic signed [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]              acc_abs;
    logic [STEP_W-1:0]             h;
    logic [DIV_W-1:0]              dvsr;
    t_div_rsp                      div_rsp;

    function automatic logic [2:0] low_row(input logic [4:0] m);
        logic [2:0] r;
        r = 3'd4;
        for (int k = 4; k >= 0; k--) begin
            if (m[k]) begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid & i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign out_load    = (r_state == S_OUT) && slot_free;

    // work out which results this sample causes
    always_comb begin
        n_seen    = (r_seen < 3'd5) ? r_seen + 3'd1 : r_seen;
        n_jobs[0] = (r_seen == 3'd4);
        n_jobs[1] = (r_seen == 3'd4);
        n_jobs[2] = (r_seen >= 3'd4);
        n_jobs[3] = i_in.last && (n_seen == 3'd5);
        n_jobs[4] = i_in.last && (n_seen == 3'd5);
        short_seq = i_in.last && (n_seen != 3'd5);
    end

    // divisor: twelve times the step, zero step replaced
    always_comb begin
        h = r_stp[r_row];
        if (h == '0) begin
            h = (r_min_step != '0) ? r_min_step : STEP_W'(1);
        end
        dvsr    = (DIV_W'(h) << 3) + (DIV_W'(h) << 2);
        acc_abs = acc[ACC_W-1] ? ACC_W'(0) - acc : acc;
    end

    // hold the minimum step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step <= MIN_STEP_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_min_step <= i_cfg.data;
        end
    end

    // shift the window on each item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < N_TAPS - 1; k++) begin
                r_smp[k] <= r_smp[k+1];
                r_stp[k] <= r_stp[k+1];
            end
            r_smp[N_TAPS-1] <= i_in.sample;
            r_stp[N_TAPS-1] <= i_in.step;
        end
    end

    // sequence results and hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 3'd0;
            r_jobs      <= 5'd0;
            r_row       <= 3'd0;
            r_mac_go    <= 1'b0;
            r_short     <= 1'b0;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mac_go <= 1'b0;
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_seen  <= n_seen;
                        r_clear <= i_in.last;
                        if (short_seq) begin
                            r_short <= 1'b1;
                            r_state <= S_OUT;
                        end else if (n_jobs != 5'd0) begin
                            r_row    <= low_row(n_jobs);
                            r_jobs   <= n_jobs & ~(5'd1 << low_row(n_jobs));
                            r_mac_go <= 1'b1;
                            r_state  <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_der   <= r_short ? '0 : div_rsp.derivative;
                        r_out_fin   <= r_short || (r_row == ROW_LAST);
                        r_out_short <= r_short;
                        r_short     <= 1'b0;
                        if (r_jobs != 5'd0) begin
                            r_row    <= low_row(r_jobs);
                            r_jobs   <= r_jobs & ~(5'd1 << low_row(r_jobs));
                            r_mac_go <= 1'b1;
                            r_state  <= S_MAC;
                        end else begin
                            if (r_clear) begin
                                r_seen <= 3'd0;
                            end
                            r_clear <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    fpd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mac_go),
        .i_row   (r_row),
        .i_win   (r_smp),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    fpd_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_done),
        .i_neg   (acc[ACC_W-1]),
        .i_mag   (acc_abs[MAG_W-1:0]),
        .i_dvsr  (dvsr),
        .o_rsp   (div_rsp)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.derivative = r_out_der;
    assign o_out.final_res  = r_out_fin;
    assign o_out.too_short  = r_out_short;

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= 3'd5) else $error("sample count beyond five");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_short |-> r_out_fin && r_out_der == '0)
        else $error("short-sequence item not zero and final");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_jobs == 5'd0 && !r_mac_go && !r_short)
        else $error("ready with results still pending");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("stalled output item dropped");

endmodule
